// ===== rtl/hdc_pkg.sv =====
// shared constants and helpers for the hemisphere direction clamp
package hdc_pkg;

  localparam int IN_BITS_DEF   = 24;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_BITS      = 24;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DOT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_UP_X    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_UP_Y    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_UP_Z    = CFG_IDX_BITS'(3);

  localparam logic signed [CFG_BITS-1:0] MIN_DOT_RST = 16'sd0;
  localparam logic signed [CFG_BITS-1:0] UP_X_RST    = 16'sd0;
  localparam logic signed [CFG_BITS-1:0] UP_Y_RST    = 16'sd0;
  localparam logic signed [CFG_BITS-1:0] UP_Z_RST    = 16'sd16384;

  // threshold is given with 14 fraction bits and limited to +-1.0
  localparam int THR_FRAC = 14;
  localparam logic signed [CFG_BITS:0] THR_MAX = 17'sd16384;
  localparam logic signed [CFG_BITS:0] THR_MIN = -17'sd16384;

  // all three magnitudes are shifted so the largest lies in [2^29, 2^30) before the root
  localparam int MAG_BITS  = 30;
  localparam int ROOT_BITS = 31;

  localparam int SAT_IN_BITS = 40;

  // pipeline depth of one normalizer
  function automatic int norm_lat(input int frac);
    return frac + ROOT_BITS + 8;
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [SAT_IN_BITS-1:0] v);
    logic signed [SAT_IN_BITS-1:0] hi;
    logic signed [SAT_IN_BITS-1:0] lo;
    hi = SAT_IN_BITS'({(OUT_BITS-1){1'b1}});
    lo = ~hi;
    if (v > hi) return hi[OUT_BITS-1:0];
    if (v < lo) return lo[OUT_BITS-1:0];
    return v[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/hemisphere_direction_clamp_top.sv =====
// hemisphere direction clamp: normalize, test against up, correct and renormalize
// the datapath is two normalizers in series, each a 31-step root pipeline followed by
// FRAC_BITS+1 divider steps
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// reset clears the valid bits and loads min_dot=0, up=(0,0,16384)
// the up normalizer runs on the registers whenever the pipeline advances, so no clearing pass is needed
module hemisphere_direction_clamp_top import hdc_pkg::*; #(
  parameter int IN_BITS   = IN_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_BITS-1:0]  vec_x,
  input  logic signed [IN_BITS-1:0]  vec_y,
  input  logic signed [IN_BITS-1:0]  vec_z,
  input  logic                       occupied,
  input  logic                       finite,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] out_x,
  output logic signed [OUT_BITS-1:0] out_y,
  output logic signed [OUT_BITS-1:0] out_z,
  output logic                       passed_through,
  output logic                       was_clamped,
  output logic                       config_error,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]        cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int NL   = norm_lat(F);
  localparam int TOT  = 2 * NL + 7;
  localparam int RW   = F + 2;
  localparam int PW   = 2 * RW + 2;
  localparam int DFW  = F + 4;
  localparam int PUW  = RW + DFW;
  localparam int WW2  = PUW + 1;
  localparam int SB1  = 1 + 3 * IN_BITS;
  localparam int SB2  = 2 + 3 * RW + 3 * IN_BITS;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  logic signed [CFG_BITS-1:0] min_dot;
  logic signed [CFG_BITS-1:0] up_x;
  logic signed [CFG_BITS-1:0] up_y;
  logic signed [CFG_BITS-1:0] up_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dot <= MIN_DOT_RST;
      up_x    <= UP_X_RST;
      up_y    <= UP_Y_RST;
      up_z    <= UP_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_DOT: min_dot <= cfg_data;
        REG_UP_X:    up_x    <= cfg_data;
        REG_UP_Y:    up_y    <= cfg_data;
        REG_UP_Z:    up_z    <= cfg_data;
        default:     min_dot <= min_dot;
      endcase
    end
  end

  // valid bits
  logic [TOT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  assign out_valid = vld[TOT-1];

  // up normalizer; the user must change the registers only while the pipeline is empty, the block does not enforce it
  logic signed [RW-1:0] up_n [3];
  logic                 up_ok;

  hdc_norm #(.WW(CFG_BITS + 1), .FRAC(F)) u_norm_up (
    .clk (clk),
    .en  (adv),
    .wx  ((CFG_BITS + 1)'(up_x)),
    .wy  ((CFG_BITS + 1)'(up_y)),
    .wz  ((CFG_BITS + 1)'(up_z)),
    .rx  (up_n[0]),
    .ry  (up_n[1]),
    .rz  (up_n[2]),
    .ok  (up_ok)
  );

  // threshold at F fraction bits
  logic signed [CFG_BITS:0] t_sat;
  logic signed [RW-1:0]     tf;

  always_comb begin
    t_sat = (CFG_BITS + 1)'(min_dot);
    if (t_sat > THR_MAX) t_sat = THR_MAX;
    if (t_sat < THR_MIN) t_sat = THR_MIN;
  end

  if (F >= THR_FRAC) begin : g_tf_up
    assign tf = RW'(t_sat) <<< (F - THR_FRAC);
  end else begin : g_tf_dn
    assign tf = RW'(t_sat >>> (THR_FRAC - F));
  end

  // first normalizer and sideband
  logic signed [RW-1:0] vn [3];
  logic                 vn_ok;
  logic [SB1-1:0]       sb1_d;
  logic [SB1-1:0]       sb1_q;

  hdc_norm #(.WW(IN_BITS + 1), .FRAC(F)) u_norm_vec (
    .clk (clk),
    .en  (adv),
    .wx  ((IN_BITS + 1)'(vec_x)),
    .wy  ((IN_BITS + 1)'(vec_y)),
    .wz  ((IN_BITS + 1)'(vec_z)),
    .rx  (vn[0]),
    .ry  (vn[1]),
    .rz  (vn[2]),
    .ok  (vn_ok)
  );

  assign sb1_d = {!(occupied && finite), vec_x, vec_y, vec_z};

  hdc_pipe #(.W(SB1), .D(NL)) u_sb1 (
    .clk (clk),
    .en  (adv),
    .d   (sb1_d),
    .q   (sb1_q)
  );

  // q1: pick vector or up fallback
  logic signed [RW-1:0]  val1 [3];
  logic [SB1-1:0]        sb_1;
  // q2: dot partial products
  logic signed [2*RW-1:0] prod2 [3];
  logic signed [RW-1:0]   val2 [3];
  logic [SB1-1:0]         sb_2;
  // q3: compare against threshold
  logic signed [PW-1:0]   p2_sum;
  logic signed [PW-1:0]   lim2;
  logic signed [PW-1:0]   d3;
  logic                   clamp3;
  logic signed [RW-1:0]   val3 [3];
  logic [SB1-1:0]         sb_3;
  // q4: correction factor
  logic signed [DFW-1:0]  df4;
  logic                   clamp4;
  logic signed [RW-1:0]   val4 [3];
  logic [SB1-1:0]         sb_4;
  // q5: up times factor
  logic signed [PUW-1:0]  pu5 [3];
  logic                   clamp5;
  logic signed [RW-1:0]   val5 [3];
  logic [SB1-1:0]         sb_5;
  // q6: corrected vector
  logic signed [WW2-1:0]  w6 [3];
  logic                   clamp6;
  logic signed [RW-1:0]   val6 [3];
  logic [SB1-1:0]         sb_6;

  assign p2_sum = PW'(prod2[0]) + PW'(prod2[1]) + PW'(prod2[2]);
  assign lim2   = PW'(tf) <<< F;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) val1[i] <= vn_ok ? vn[i] : up_n[i];
      sb_1 <= sb1_q;

      for (int i = 0; i < 3; i++) prod2[i] <= (2*RW)'(val1[i]) * (2*RW)'(up_n[i]);
      val2 <= val1;
      sb_2 <= sb_1;

      clamp3 <= p2_sum < lim2;
      d3     <= lim2 - p2_sum;
      val3   <= val2;
      sb_3   <= sb_2;

      df4    <= DFW'((d3 + (PW'(1) <<< (F - 1))) >>> F);
      clamp4 <= clamp3;
      val4   <= val3;
      sb_4   <= sb_3;

      for (int i = 0; i < 3; i++) pu5[i] <= PUW'(up_n[i]) * PUW'(df4);
      clamp5 <= clamp4;
      val5   <= val4;
      sb_5   <= sb_4;

      for (int i = 0; i < 3; i++) w6[i] <= (WW2'(val5[i]) <<< F) + WW2'(pu5[i]);
      clamp6 <= clamp5;
      val6   <= val5;
      sb_6   <= sb_5;
    end
  end

  // second normalizer and sideband
  logic signed [RW-1:0] cn [3];
  logic                 cn_ok;
  logic [SB2-1:0]       sb2_d;
  logic [SB2-1:0]       sb2_q;

  hdc_norm #(.WW(WW2), .FRAC(F)) u_norm_fix (
    .clk (clk),
    .en  (adv),
    .wx  (w6[0]),
    .wy  (w6[1]),
    .wz  (w6[2]),
    .rx  (cn[0]),
    .ry  (cn[1]),
    .rz  (cn[2]),
    .ok  (cn_ok)
  );

  assign sb2_d = {clamp6, val6[0], val6[1], val6[2], sb_6};

  hdc_pipe #(.W(SB2), .D(NL)) u_sb2 (
    .clk (clk),
    .en  (adv),
    .d   (sb2_d),
    .q   (sb2_q)
  );

  // final selection
  logic                 f_clamp;
  logic                 f_pass;
  logic signed [RW-1:0] f_val [3];
  logic [IN_BITS-1:0]   f_raw [3];
  logic signed [RW-1:0] f_res [3];
  logic [OUT_BITS-1:0]  f_out [3];

  always_comb begin
    f_clamp  = sb2_q[SB2-1];
    f_val[0] = sb2_q[SB2-2 -: RW];
    f_val[1] = sb2_q[SB2-2-RW -: RW];
    f_val[2] = sb2_q[SB2-2-2*RW -: RW];
    f_pass   = sb2_q[SB1-1];
    f_raw[0] = sb2_q[3*IN_BITS-1 -: IN_BITS];
    f_raw[1] = sb2_q[2*IN_BITS-1 -: IN_BITS];
    f_raw[2] = sb2_q[IN_BITS-1 -: IN_BITS];
    for (int i = 0; i < 3; i++) begin
      if (f_clamp) f_res[i] = cn_ok ? cn[i] : up_n[i];
      else         f_res[i] = f_val[i];
      if (!up_ok)      f_out[i] = '0;
      else if (f_pass) f_out[i] = OUT_BITS'(f_raw[i]);
      else             f_out[i] = sat_out(SAT_IN_BITS'(f_res[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x          <= f_out[0];
      out_y          <= f_out[1];
      out_z          <= f_out[2];
      config_error   <= !up_ok;
      passed_through <= up_ok && f_pass;
      was_clamped    <= up_ok && !f_pass && f_clamp;
    end
  end

endmodule

// ===== rtl/hdc_pipe.sv =====
// plain delay line for sideband data with a shared advance enable
module hdc_pipe #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < D; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[D-1];

endmodule

// ===== rtl/hdc_norm.sv =====
// pipelined vector normalizer: magnitude scaling, square root, three dividers
module hdc_norm import hdc_pkg::*; #(
  parameter int WW   = 25,
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [WW-1:0]   wx,
  input  logic signed [WW-1:0]   wy,
  input  logic signed [WW-1:0]   wz,
  output logic signed [FRAC+1:0] rx,
  output logic signed [FRAC+1:0] ry,
  output logic signed [FRAC+1:0] rz,
  output logic                   ok
);

  localparam int MSBW = $clog2(WW + 1);
  localparam int SQW  = 2 * MAG_BITS;
  localparam int SW   = 2 * ROOT_BITS + 2;
  localparam int QB   = FRAC + 1;
  localparam int DW   = MAG_BITS + FRAC + 2;
  localparam int RW   = FRAC + 2;

  // stage 1: magnitudes and largest one
  logic signed [WW-1:0] w_in [3];
  logic [WW-1:0] a_m [3];
  logic [WW-1:0] a_mx;
  logic [WW-1:0] s1_m [3];
  logic [2:0]    s1_neg;
  logic [WW-1:0] s1_mx;

  assign w_in[0] = wx;
  assign w_in[1] = wy;
  assign w_in[2] = wz;

  always_comb begin
    a_mx = '0;
    for (int i = 0; i < 3; i++) begin
      a_m[i] = w_in[i][WW-1] ? WW'(-w_in[i]) : WW'(w_in[i]);
      if (a_m[i] > a_mx) a_mx = a_m[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m  <= a_m;
      s1_mx <= a_mx;
      for (int i = 0; i < 3; i++) s1_neg[i] <= w_in[i][WW-1];
    end
  end

  // stage 2: leading one position
  logic [MSBW-1:0] b_msb;
  logic [WW-1:0]   s2_m [3];
  logic [2:0]      s2_neg;
  logic [MSBW-1:0] s2_msb;
  logic            s2_ok;

  always_comb begin
    b_msb = '0;
    for (int i = 0; i < WW; i++) begin
      if (s1_mx[i]) b_msb = MSBW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m   <= s1_m;
      s2_neg <= s1_neg;
      s2_msb <= b_msb;
      s2_ok  <= |s1_mx;
    end
  end

  // stage 3: place the leading one at bit MAG_BITS-1
  logic [WW+MAG_BITS-1:0] c_ext [3];
  logic [MAG_BITS-1:0] s3_m [3];
  logic [2:0]          s3_neg;
  logic                s3_ok;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_ext[i] = {s2_m[i], {MAG_BITS{1'b0}}} >> ({1'b0, s2_msb} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_m[i] <= c_ext[i][MAG_BITS-1:0];
      s3_neg <= s2_neg;
      s3_ok  <= s2_ok;
    end
  end

  // stage 4: squares
  logic [SQW-1:0]      s4_sq [3];
  logic [MAG_BITS-1:0] s4_m [3];
  logic [2:0]          s4_neg;
  logic                s4_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_sq[i] <= SQW'(s3_m[i]) * SQW'(s3_m[i]);
      s4_m   <= s3_m;
      s4_neg <= s3_neg;
      s4_ok  <= s3_ok;
    end
  end

  // stage 5 and root steps, one result bit per stage
  logic [SW-1:0]        sq_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root [ROOT_BITS+1];
  logic [MAG_BITS-1:0]  sq_m    [ROOT_BITS+1][3];
  logic [2:0]           sq_neg  [ROOT_BITS+1];
  logic                 sq_ok   [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SW'(s4_sq[0]) + SW'(s4_sq[1]) + SW'(s4_sq[2]);
      sq_root[0] <= '0;
      sq_m[0]    <= s4_m;
      sq_neg[0]  <= s4_neg;
      sq_ok[0]   <= s4_ok;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int B = ROOT_BITS - 1 - k;
    logic [SW-1:0] cand;
    assign cand = (SW'(sq_root[k]) << (B + 1)) + (SW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[k] >= cand) begin
          sq_rem[k+1]  <= sq_rem[k] - cand;
          sq_root[k+1] <= sq_root[k] | (ROOT_BITS'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
        sq_m[k+1]   <= sq_m[k];
        sq_neg[k+1] <= sq_neg[k];
        sq_ok[k+1]  <= sq_ok[k];
      end
    end
  end

  // divider setup, then one quotient bit per stage on three lanes
  logic [DW-1:0] dv_rem [QB+1][3];
  logic [QB-1:0] dv_q   [QB+1][3];
  logic [DW-1:0] dv_d   [QB+1];
  logic [2:0]    dv_neg [QB+1];
  logic          dv_ok  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (DW'(sq_m[ROOT_BITS][i]) << (FRAC + 1)) + DW'(sq_root[ROOT_BITS]);
        dv_q[0][i]   <= '0;
      end
      dv_d[0]   <= DW'(sq_root[ROOT_BITS]) << 1;
      dv_neg[0] <= sq_neg[ROOT_BITS];
      dv_ok[0]  <= sq_ok[ROOT_BITS];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [DW-1:0] trial;
    assign trial = dv_d[j] << B;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= trial) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - trial;
            dv_q[j+1][i]   <= dv_q[j][i] | (QB'(1) << B);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_d[j+1]   <= dv_d[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_ok[j+1]  <= dv_ok[j];
      end
    end
  end

  // sign back on
  logic signed [RW-1:0] r_out [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_out[i] <= dv_neg[QB][i] ? -$signed(RW'(dv_q[QB][i])) : $signed(RW'(dv_q[QB][i]));
      end
      ok <= dv_ok[QB];
    end
  end

  assign rx = r_out[0];
  assign ry = r_out[1];
  assign rz = r_out[2];

endmodule
